FILE: hdl/pogc_pkg.sv
package pogc_pkg;

  localparam int PIX_W          = 16;
  localparam int GAIN_FRAC_BITS = 10;
  localparam int DVD_W          = 2 * PIX_W;
  localparam int STEPS_PER_STG  = 4;
  localparam int DIV_STGS       = PIX_W / STEPS_PER_STG;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = PIX_W;

  localparam logic [PIX_W-1:0] PEDESTAL = PIX_W'(100);
  localparam logic [PIX_W-1:0] SAT_RST  = PIX_W'(100);

  typedef enum logic [1:0] {
    MODE_RAW0      = 2'd0,
    MODE_RAW1      = 2'd1,
    MODE_TWO_FRAME = 2'd2,
    MODE_RAW3      = 2'd3
  } pogc_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_MODE = 2'd0,
    REG_GAIN_ENABLE = 2'd1,
    REG_SATURATION  = 2'd2,
    REG_UNUSED      = 2'd3
  } pogc_reg_t;

  // one pipeline slot: control flags plus divider working set
  typedef struct packed {
    logic             vld;
    logic             byp;
    logic             zero;
    logic             ovf;
    logic [PIX_W-1:0] val;
    logic [PIX_W-1:0] gain;
    logic [PIX_W-1:0] rem;
    logic [PIX_W-1:0] quo;
    logic [PIX_W-1:0] dvd;
  } pogc_stage_t;

  // one restoring division step
  function automatic pogc_stage_t div_step(pogc_stage_t s);
    logic [PIX_W:0] t;
    pogc_stage_t    r;
    r = s;
    t = {s.rem, s.dvd[PIX_W-1]};
    if (t >= {1'b0, s.gain}) begin
      r.rem = PIX_W'(t - {1'b0, s.gain});
      r.quo = {s.quo[PIX_W-2:0], 1'b1};
    end else begin
      r.rem = t[PIX_W-1:0];
      r.quo = {s.quo[PIX_W-2:0], 1'b0};
    end
    r.dvd = {s.dvd[PIX_W-2:0], 1'b0};
    return r;
  endfunction

endpackage

FILE: hdl/pixel_offset_gain_correction.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | bright_pixel, dark_pixel, gain_word
// out_    | output    | out_valid/out_stall| corrected_pixel, zero_gain
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one pixel beat can enter every cycle while in_stall is low
// path: offset slot, 4-stage restoring divider (4 bits per stage), output register
// synchronous active-low reset clears valid bits and sets config registers to reset values
// a stall on out_ freezes the whole pipe; in_stall follows it when out is full
// bubbles are never squeezed while stalled, so nothing is lost or repeated
module pixel_offset_gain_correction (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pogc_pkg::PIX_W-1:0]     in_bright_pixel,
  input  logic [pogc_pkg::PIX_W-1:0]     in_dark_pixel,
  input  logic [pogc_pkg::PIX_W-1:0]     in_gain_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pogc_pkg::PIX_W-1:0]     out_corrected_pixel,
  output logic                           out_zero_gain,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pogc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pogc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pogc_pkg::*;

  // configuration registers
  pogc_mode_t       mode_r;
  logic             gain_en_r;
  logic [PIX_W-1:0] sat_r;

  // pipe: slot 0 holds the offset result, slots 1..DIV_STGS the divider
  pogc_stage_t      s_r   [0:DIV_STGS];
  pogc_stage_t      s_nxt [0:DIV_STGS];

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_zero_r;
  logic [PIX_W-1:0] out_pix_nxt;

  logic             adv;
  logic             two_frame;
  logic [PIX_W-1:0] offs;
  logic [PIX_W-1:0] diff;
  logic [DVD_W-1:0] dividend;

  // pipe moves whenever the output slot is free or being taken
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  assign out_valid           = out_valid_r;
  assign out_corrected_pixel = out_pix_r;
  assign out_zero_gain       = out_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RAW0;
      gain_en_r <= 1'b0;
      sat_r     <= SAT_RST;
    end else if (cfg_valid) begin
      unique case (pogc_reg_t'(cfg_index))
        REG_OFFSET_MODE: mode_r    <= pogc_mode_t'(cfg_data[1:0]);
        REG_GAIN_ENABLE: gain_en_r <= cfg_data[0];
        REG_SATURATION:  sat_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: dark subtraction with pedestal and saturation clamp in two-frame mode, raw bright pixel otherwise
  assign two_frame = (mode_r == MODE_TWO_FRAME);
  assign diff      = in_dark_pixel - in_bright_pixel;

  always_comb begin
    if (in_bright_pixel >= sat_r) begin
      offs = sat_r;
    end else if (in_bright_pixel >= in_dark_pixel) begin
      offs = in_bright_pixel - in_dark_pixel + PEDESTAL;
    end else if (diff <= PEDESTAL) begin
      offs = PEDESTAL - diff;
    end else begin
      offs = PEDESTAL;
    end
  end

  always_comb begin
    s_nxt[0]      = '0;
    s_nxt[0].vld  = in_valid;
    s_nxt[0].byp  = !(two_frame && gain_en_r);
    s_nxt[0].zero = two_frame && gain_en_r && (in_gain_word == '0);
    s_nxt[0].val  = two_frame ? offs : in_bright_pixel;
    s_nxt[0].gain = in_gain_word;
  end

  // stage 1: quotient range check, remainder seed, first division steps
  // a quotient of 2^16 or more always clamps, so only 16 quotient bits are built
  assign dividend = DVD_W'(s_r[0].val) << GAIN_FRAC_BITS;

  always_comb begin
    s_nxt[1]     = s_r[0];
    s_nxt[1].ovf = dividend >= {s_r[0].gain, {PIX_W{1'b0}}};
    s_nxt[1].rem = dividend[DVD_W-1:PIX_W];
    s_nxt[1].dvd = dividend[PIX_W-1:0];
    s_nxt[1].quo = '0;
    for (int k = 0; k < STEPS_PER_STG; k++) begin
      s_nxt[1] = div_step(s_nxt[1]);
    end
  end

  // remaining divider stages
  for (genvar g = 2; g <= DIV_STGS; g++) begin : g_div
    always_comb begin
      s_nxt[g] = s_r[g-1];
      for (int k = 0; k < STEPS_PER_STG; k++) begin
        s_nxt[g] = div_step(s_nxt[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= DIV_STGS; i++) begin
      if (!rst_n) begin
        s_r[i].vld <= 1'b0;
      end else if (adv) begin
        s_r[i] <= s_nxt[i];
      end
    end
  end

  // final stage: clamp against saturation and select
  always_comb begin
    if (s_r[DIV_STGS].byp) begin
      out_pix_nxt = s_r[DIV_STGS].val;
    end else if (s_r[DIV_STGS].zero || s_r[DIV_STGS].ovf || s_r[DIV_STGS].quo >= sat_r) begin
      out_pix_nxt = sat_r;
    end else begin
      out_pix_nxt = s_r[DIV_STGS].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s_r[DIV_STGS].vld;
      out_pix_r   <= out_pix_nxt;
      out_zero_r  <= s_r[DIV_STGS].zero;
    end
  end

  // zero gain always saturates
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_gain |-> out_corrected_pixel == sat_r)
    else $error("zero gain beat not saturated");

  // zero gain only reachable with two-frame mode and gain on
  a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_gain |-> mode_r == MODE_TWO_FRAME && gain_en_r)
    else $error("zero gain flag outside gain path");

  // gain path output never exceeds the clamp
  a_gain_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r == MODE_TWO_FRAME && gain_en_r |-> out_corrected_pixel <= sat_r)
    else $error("gain result above saturation");

  // input back-pressure only when the output slot is held
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

endmodule
